// ----- hdl/trc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_pkg
// Widths, limits and sequencer states shared by the run centroid core and its
// channel interfaces.
// ----------------------------------------------------------------------------
package trc_pkg;

   localparam int MAX_LENGTH    = 4096;
   localparam int FRACTION_BITS = 8;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = $clog2(MAX_LENGTH);
   localparam int COUNT_W  = $clog2(MAX_LENGTH + 1);
   localparam int POS_W    = 20;
   localparam int TALLY_W  = 13;
   localparam int PROD_W   = SAMPLE_W + INDEX_W;

   // run sums are sized for runs of up to 2^20 samples
   localparam int LSUM_W     = SAMPLE_W + 20;
   localparam int WSUM_W     = LSUM_W + INDEX_W;
   localparam int DIVIDEND_W = WSUM_W + FRACTION_BITS;
   // centroid never exceeds (MAX_LENGTH-1)+1 in fixed point
   localparam int QUO_W      = INDEX_W + FRACTION_BITS + 1;
   localparam int DCNT_W     = $clog2(QUO_W);

   localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_ACCUM,
      ST_SETUP,
      ST_DIVIDE,
      ST_CLAMP,
      ST_RESPOND
   } trc_state_type;

endpackage

// ----- hdl/trc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_req_if
// Sample channel: one profile sample and its last-sample mark per transaction.
// ----------------------------------------------------------------------------
interface trc_req_if;
   logic                         valid;
   logic                         ready;
   logic [trc_pkg::SAMPLE_W-1:0] sample_value;
   logic                         final_sample;

   modport source (output valid, output sample_value, output final_sample, input ready);
   modport sink   (input valid, input sample_value, input final_sample, output ready);
endinterface

// ----- hdl/trc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_rsp_if
// Result channel: one line report or end-of-profile report per transaction.
// ----------------------------------------------------------------------------
interface trc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        line_found;
   logic [trc_pkg::POS_W-1:0]   line_position;
   logic [trc_pkg::TALLY_W-1:0] lines_so_far;
   logic                        profile_done;
   logic                        length_overflow;

   modport source (output valid, output line_found, output line_position,
                   output lines_so_far, output profile_done, output length_overflow,
                   input ready);
   modport sink   (input valid, input line_found, input line_position,
                   input lines_so_far, input profile_done, input length_overflow,
                   output ready);
endinterface

// ----- hdl/threshold_run_centroid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_run_centroid_core
// Finds runs of samples at or above a threshold in a profile and reports the
// weighted centroid of each run in unsigned 12.8 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one sample per transaction, final_sample on the last one.
//   rsp_bus carries a result when a run closes (a sample below threshold or
//   the last sample) and always one for the last sample, with the line count.
//   csr_write_enable/csr_write_data load the 16-bit level threshold; write it
//   only while the core is idle.
// Timing:
//   one sample is in flight at a time; req_bus.ready is high only when idle.
//   a sample that closes no run goes through accept, multiply, accumulate and
//   decide. a closed run with a nonzero sum then goes through the shared
//   restoring divider (one quotient bit per cycle, 21 bits) and the clamp,
//   and then waits in the result state until taken. a zero-sum run reports its
//   midpoint without dividing.
// Reset:
//   synchronous; clears the threshold, the index counter, run and tally state.
// Stall:
//   a result is held on rsp_bus until taken; no new sample is accepted
//   meanwhile. after the last sample's result the profile state is cleared.
// ----------------------------------------------------------------------------
module threshold_run_centroid_core (
   input  logic                         clock,
   input  logic                         reset,
   trc_req_if.sink                      req_bus,
   trc_rsp_if.source                    rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [trc_pkg::SAMPLE_W-1:0] csr_write_data
);

   trc_pkg::trc_state_type state_ff, state_in;

   logic [trc_pkg::SAMPLE_W-1:0]   threshold_ff, threshold_in;
   logic [trc_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                           overflow_ff, overflow_in;
   logic                           inside_ff, inside_in;
   logic [trc_pkg::INDEX_W-1:0]    first_ff, first_in;
   logic [trc_pkg::INDEX_W-1:0]    last_ff, last_in;
   logic [trc_pkg::WSUM_W-1:0]     wsum_ff, wsum_in;
   logic [trc_pkg::LSUM_W-1:0]     lsum_ff, lsum_in;
   logic [trc_pkg::TALLY_W-1:0]    tally_ff, tally_in;

   logic [trc_pkg::SAMPLE_W-1:0]   value_ff, value_in;
   logic [trc_pkg::INDEX_W-1:0]    index_ff, index_in;
   logic                           final_ff, final_in;
   logic                           above_ff, above_in;
   logic [trc_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                           found_ff, found_in;
   logic [trc_pkg::POS_W-1:0]      pos_ff, pos_in;

   logic [trc_pkg::LSUM_W-1:0]     rem_ff, rem_in;
   logic [trc_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [trc_pkg::DCNT_W-1:0]     dcnt_ff, dcnt_in;

   logic                           req_accept;
   logic                           rsp_accept;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [trc_pkg::DIVIDEND_W-1:0] dividend;
   logic [trc_pkg::INDEX_W:0]      mid_sum;
   logic [trc_pkg::QUO_W-1:0]      midpoint;
   logic [trc_pkg::LSUM_W:0]       shifted;
   logic [trc_pkg::LSUM_W+1:0]     trial;

   assign req_accept = req_bus.valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_bus.ready;

   // dividend = weighted_sum * 2^F + level_sum/2 gives round-half-up in one pass
   assign dividend = {wsum_ff, {trc_pkg::FRACTION_BITS{1'b0}}}
                     + trc_pkg::DIVIDEND_W'(lsum_ff >> 1);
   assign mid_sum  = {1'b0, first_ff} + {1'b0, last_ff};
   assign midpoint = trc_pkg::QUO_W'(mid_sum) << (trc_pkg::FRACTION_BITS - 1);

   // shared subtract unit of the restoring divider
   assign shifted = {rem_ff, quo_ff[trc_pkg::QUO_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, lsum_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = trc_pkg::ST_MULT;
            end
         end
         trc_pkg::ST_MULT: begin
            state_in = trc_pkg::ST_ACCUM;
         end
         trc_pkg::ST_ACCUM: begin
            state_in = trc_pkg::ST_SETUP;
         end
         trc_pkg::ST_SETUP: begin
            if (found_ff && lsum_ff != '0) begin
               state_in = trc_pkg::ST_DIVIDE;
            end else if (found_ff || final_ff) begin
               state_in = trc_pkg::ST_RESPOND;
            end else begin
               state_in = trc_pkg::ST_IDLE;
            end
         end
         trc_pkg::ST_DIVIDE: begin
            if (dcnt_ff == trc_pkg::DCNT_W'(trc_pkg::QUO_W - 1)) begin
               state_in = trc_pkg::ST_CLAMP;
            end
         end
         trc_pkg::ST_CLAMP: begin
            state_in = trc_pkg::ST_RESPOND;
         end
         trc_pkg::ST_RESPOND: begin
            if (rsp_accept) begin
               state_in = trc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trc_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         trc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         trc_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      threshold_in = threshold_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      inside_in    = inside_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      wsum_in      = wsum_ff;
      lsum_in      = lsum_ff;
      tally_in     = tally_ff;
      value_in     = value_ff;
      index_in     = index_ff;
      final_in     = final_ff;
      above_in     = above_ff;
      prod_in      = prod_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;

      if (csr_write_enable) begin
         threshold_in = csr_write_data;
      end

      case (state_ff)
         trc_pkg::ST_IDLE: begin
            if (req_accept) begin
               value_in = req_bus.sample_value;
               final_in = req_bus.final_sample;
               above_in = req_bus.sample_value >= threshold_ff;
               // past the maximum length the index sticks at the last slot
               if (count_ff >= trc_pkg::COUNT_W'(trc_pkg::MAX_LENGTH)) begin
                  index_in    = trc_pkg::INDEX_W'(trc_pkg::MAX_LENGTH - 1);
                  overflow_in = 1'b1;
               end else begin
                  index_in = count_ff[trc_pkg::INDEX_W-1:0];
                  count_in = count_ff + 1'b1;
               end
            end
         end
         trc_pkg::ST_MULT: begin
            prod_in = trc_pkg::PROD_W'(value_ff) * trc_pkg::PROD_W'(index_ff);
         end
         trc_pkg::ST_ACCUM: begin
            pos_in = '0;
            if (above_ff) begin
               if (!inside_ff) begin
                  first_in = index_ff;
                  wsum_in  = trc_pkg::WSUM_W'(prod_ff);
                  lsum_in  = trc_pkg::LSUM_W'(value_ff);
               end else begin
                  wsum_in = wsum_ff + trc_pkg::WSUM_W'(prod_ff);
                  lsum_in = lsum_ff + trc_pkg::LSUM_W'(value_ff);
               end
               last_in   = index_ff;
               found_in  = final_ff;
               inside_in = !final_ff;
            end else begin
               found_in  = inside_ff;
               inside_in = 1'b0;
            end
         end
         trc_pkg::ST_SETUP: begin
            if (found_ff && tally_ff != trc_pkg::TALLY_MAX) begin
               tally_in = tally_ff + 1'b1;
            end
            rem_in  = trc_pkg::LSUM_W'(dividend[trc_pkg::DIVIDEND_W-1:trc_pkg::QUO_W]);
            quo_in  = dividend[trc_pkg::QUO_W-1:0];
            dcnt_in = '0;
            if (found_ff && lsum_ff == '0) begin
               pos_in = (midpoint > trc_pkg::QUO_W'(trc_pkg::POS_MAX)) ?
                        trc_pkg::POS_MAX : midpoint[trc_pkg::POS_W-1:0];
            end
         end
         trc_pkg::ST_DIVIDE: begin
            if (!trial[trc_pkg::LSUM_W+1]) begin
               rem_in = trial[trc_pkg::LSUM_W-1:0];
               quo_in = {quo_ff[trc_pkg::QUO_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[trc_pkg::LSUM_W-1:0];
               quo_in = {quo_ff[trc_pkg::QUO_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
         end
         trc_pkg::ST_CLAMP: begin
            pos_in = (quo_ff > trc_pkg::QUO_W'(trc_pkg::POS_MAX)) ?
                     trc_pkg::POS_MAX : quo_ff[trc_pkg::POS_W-1:0];
         end
         trc_pkg::ST_RESPOND: begin
            // last sample of the profile: back to a clean profile
            if (rsp_accept && final_ff) begin
               count_in    = '0;
               overflow_in = 1'b0;
               inside_in   = 1'b0;
               first_in    = '0;
               last_in     = '0;
               wsum_in     = '0;
               lsum_in     = '0;
               tally_in    = '0;
            end
         end
         default: begin
            dcnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trc_pkg::ST_IDLE;
         threshold_ff <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         inside_ff    <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         wsum_ff      <= '0;
         lsum_ff      <= '0;
         tally_ff     <= '0;
         found_ff     <= 1'b0;
         final_ff     <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         inside_ff    <= inside_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         wsum_ff      <= wsum_in;
         lsum_ff      <= lsum_in;
         tally_ff     <= tally_in;
         found_ff     <= found_in;
         final_ff     <= final_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      index_ff <= index_in;
      above_ff <= above_in;
      prod_ff  <= prod_in;
      pos_ff   <= pos_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign req_bus.ready           = req_ready;
   assign rsp_bus.valid           = rsp_valid;
   assign rsp_bus.line_found      = found_ff;
   assign rsp_bus.line_position   = pos_ff;
   assign rsp_bus.lines_so_far    = tally_ff;
   assign rsp_bus.profile_done    = final_ff;
   assign rsp_bus.length_overflow = overflow_ff;

   // never taking a sample while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("sample accepted while a result is pending");

   // a report with no line carries a zero position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !found_ff) |-> (pos_ff == '0))
      else $error("position set on a result without a line");

   // profile state is clean after the last sample's result is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && final_ff) |=> (tally_ff == '0 && count_ff == '0 && !inside_ff))
      else $error("profile state not cleared after last sample");

   // divider step counter stays within the quotient width
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == trc_pkg::ST_DIVIDE) |-> (dcnt_ff < trc_pkg::DCNT_W'(trc_pkg::QUO_W)))
      else $error("divider step count out of range");

endmodule

// ----- dv/trc_line_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trc_line_monitor
// Watches the sample, result and threshold ports of the run centroid core.
// Keeps its own copy of the profile state, works out the line report that each
// accepted sample should cause and compares every result field by field.
// ----------------------------------------------------------------------------
module trc_line_monitor (
   input  logic                         clock,
   input  logic                         reset,
   trc_req_if                           req_bus,
   trc_rsp_if                           rsp_bus,
   input  logic                         csr_write_enable,
   input  logic [trc_pkg::SAMPLE_W-1:0] csr_write_data,
   output int                           mismatch_count,
   output int                           reports_outstanding
);

   typedef struct packed {
      logic                        line_found;
      logic [trc_pkg::POS_W-1:0]   line_position;
      logic [trc_pkg::TALLY_W-1:0] lines_so_far;
      logic                        profile_done;
      logic                        length_overflow;
   } line_report_type;

   logic [trc_pkg::SAMPLE_W-1:0] level_threshold;
   logic [trc_pkg::INDEX_W:0]    next_index;
   logic                         in_run;
   logic [trc_pkg::INDEX_W-1:0]  first_idx;
   logic [trc_pkg::INDEX_W-1:0]  last_idx;
   logic [63:0]                  weight_acc;
   logic [63:0]                  level_acc;
   logic [trc_pkg::TALLY_W-1:0]  tally;
   logic                         overflowed;

   line_report_type expected_reports[$];
   int              result_count;

   task automatic clear_profile();
      next_index = '0;
      in_run     = 1'b0;
      first_idx  = '0;
      last_idx   = '0;
      weight_acc = '0;
      level_acc  = '0;
      tally      = '0;
      overflowed = 1'b0;
   endtask

   // centroid rounded to nearest, or the midpoint of a zero-sum run
   function automatic logic [trc_pkg::POS_W-1:0] centroid_fixed();
      logic [63:0] quo;
      logic [63:0] rem;
      logic [63:0] frac;
      logic [63:0] pos;
      if (level_acc != 0) begin
         quo  = weight_acc / level_acc;
         rem  = weight_acc % level_acc;
         frac = ((rem << trc_pkg::FRACTION_BITS) + (level_acc >> 1)) / level_acc;
         pos  = (quo << trc_pkg::FRACTION_BITS) + frac;
      end else begin
         pos = (64'(first_idx) + 64'(last_idx)) << (trc_pkg::FRACTION_BITS - 1);
      end
      return (pos > 64'(trc_pkg::POS_MAX)) ? trc_pkg::POS_MAX : pos[trc_pkg::POS_W-1:0];
   endfunction

   task automatic predict_line_report(input logic [trc_pkg::SAMPLE_W-1:0] v,
                                      input logic fin);
      logic [trc_pkg::INDEX_W-1:0] idx;
      logic                        found;
      logic [trc_pkg::POS_W-1:0]   pos;
      line_report_type             rpt;
      found = 1'b0;
      pos   = '0;
      // indices saturate once the profile is longer than the maximum
      if (next_index >= trc_pkg::MAX_LENGTH) begin
         idx        = trc_pkg::INDEX_W'(trc_pkg::MAX_LENGTH - 1);
         overflowed = 1'b1;
      end else begin
         idx        = next_index[trc_pkg::INDEX_W-1:0];
         next_index = next_index + 1'b1;
      end
      if (v >= level_threshold) begin
         if (!in_run) begin
            in_run     = 1'b1;
            first_idx  = idx;
            weight_acc = '0;
            level_acc  = '0;
         end
         last_idx   = idx;
         weight_acc = weight_acc + 64'(v) * 64'(idx);
         level_acc  = level_acc + 64'(v);
         if (fin) begin
            found  = 1'b1;
            pos    = centroid_fixed();
            in_run = 1'b0;
         end
      end else if (in_run) begin
         found  = 1'b1;
         pos    = centroid_fixed();
         in_run = 1'b0;
      end
      if (found && tally != trc_pkg::TALLY_MAX) tally = tally + 1'b1;
      if (found || fin) begin
         rpt.line_found      = found;
         rpt.line_position   = pos;
         rpt.lines_so_far    = tally;
         rpt.profile_done    = fin;
         rpt.length_overflow = overflowed;
         expected_reports.push_back(rpt);
      end
      if (fin) clear_profile();
   endtask

   task automatic report_mismatch(input string msg);
      $display("ERROR: t=%0t result %0d: %s", $realtime, result_count, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      line_report_type want;
      if (reset) begin
         level_threshold = '0;
         clear_profile();
         expected_reports.delete();
         result_count   = 0;
         mismatch_count = 0;
      end else begin
         // an older result can never be caused by this edge's sample
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_reports.size() == 0) begin
               report_mismatch("transaction with no line report waiting");
            end else begin
               want = expected_reports.pop_front();
               compare_field("line_found", 32'(rsp_bus.line_found), 32'(want.line_found));
               compare_field("line_position", 32'(rsp_bus.line_position),
                             32'(want.line_position));
               compare_field("lines_so_far", 32'(rsp_bus.lines_so_far),
                             32'(want.lines_so_far));
               compare_field("profile_done", 32'(rsp_bus.profile_done),
                             32'(want.profile_done));
               compare_field("length_overflow", 32'(rsp_bus.length_overflow),
                             32'(want.length_overflow));
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_line_report(req_bus.sample_value, req_bus.final_sample);
         if (csr_write_enable) level_threshold = csr_write_data;
      end
      reports_outstanding <= expected_reports.size();
   end

endmodule

// ----- dv/threshold_run_centroid_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_run_centroid_core_tb
// Drives profiles into the run centroid core under several thresholds:
// directed edge profiles, then random run-shaped profiles, with random stalls
// on both channels (none in the last phase). The line monitor checks every result.
// ----------------------------------------------------------------------------
module threshold_run_centroid_core_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE_TIME = 40;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [trc_pkg::SAMPLE_W-1:0] csr_write_data;
   logic                         steady_run;
   int                           mismatch_count;
   int                           reports_outstanding;
   int                           idle_cycles;

   trc_req_if req_bus ();
   trc_rsp_if rsp_bus ();

   threshold_run_centroid_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   trc_line_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_bus             (req_bus),
      .rsp_bus             (rsp_bus),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .reports_outstanding (reports_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!steady_run) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // returns in the time step of the accepting edge, valid still high
   task automatic send_sample(input logic [trc_pkg::SAMPLE_W-1:0] v, input logic fin);
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.sample_value <= v;
      req_bus.final_sample <= fin;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (reports_outstanding != 0);
      // a sample that closes no run may still be in the core
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [trc_pkg::SAMPLE_W-1:0] t);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= t;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [trc_pkg::SAMPLE_W-1:0] pick_sample(
      input logic high, input logic [trc_pkg::SAMPLE_W-1:0] t);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return trc_pkg::SAMPLE_W'($urandom);
      if (high || t == 0) begin
         case (sel)
            1, 2:    return t;
            3:       return {trc_pkg::SAMPLE_W{1'b1}};
            default: return trc_pkg::SAMPLE_W'($urandom_range(int'(t), 65535));
         endcase
      end
      case (sel)
         1, 2:    return t - 1'b1;
         3:       return '0;
         default: return trc_pkg::SAMPLE_W'($urandom_range(0, int'(t) - 1));
      endcase
   endfunction

   task automatic random_profiles(input int item_goal,
                                  input logic [trc_pkg::SAMPLE_W-1:0] t);
      int   sent;
      int   len;
      logic high;
      sent = 0;
      while (sent < item_goal) begin
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 60) : $urandom_range(1, 20);
         high = 1'($urandom_range(0, 1));
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 2) == 0) high = !high;
            send_sample(pick_sample(high, t), k == len - 1);
         end
         sent += len;
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
   endtask

   initial begin
      logic [trc_pkg::SAMPLE_W-1:0] t;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.sample_value <= '0;
      req_bus.final_sample <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= '0;
      steady_run           <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // threshold still at reset value: zero-sum run gives the midpoint
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1);
      send_sample(16'hFFFF, 1'b1);

      write_threshold(16'h8000);
      // run closed by a low sample, then a run closed by a low final sample
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h1234, 1'b1);
      // final sample with nothing to close
      send_sample(16'h0000, 1'b1);
      // run closed by a high final sample
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b1);

      write_threshold(16'hFFFF);
      send_sample(16'hFFFE, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFE, 1'b1);
      send_sample(16'hFFFF, 1'b1);

      t = trc_pkg::SAMPLE_W'($urandom);
      write_threshold(t);
      random_profiles(90, t);
      write_threshold(16'h0000);
      random_profiles(90, 16'h0000);
      write_threshold(16'hFFFF);
      random_profiles(90, 16'hFFFF);

      steady_run <= 1'b1;
      t = trc_pkg::SAMPLE_W'($urandom);
      write_threshold(t);
      random_profiles(90, t);

      wait_drained();
      if (mismatch_count == 0 && reports_outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/trc_pkg.sv
hdl/trc_req_if.sv
hdl/trc_rsp_if.sv
hdl/threshold_run_centroid_core.sv
dv/trc_line_monitor.sv
dv/threshold_run_centroid_core_tb.sv
